>>> design/bba_pkg.sv
`default_nettype none
package bba_pkg;

  localparam int ADDR_W    = 32;
  localparam int SIZE_W    = 16;
  localparam int CNT_W     = 11;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_DW    = 27;
  localparam int DIV_QW    = 11;
  localparam int DIV_CW    = $clog2(DIV_QW);

  localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_EXHAUSTED   = 3'd1,
    ST_NULL        = 3'd2,
    ST_RANGE       = 3'd3,
    ST_MISALIGNED  = 3'd4,
    ST_DOUBLE_FREE = 3'd5
  } status_t;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_QW-1:0] quotient;
    logic [SIZE_W-1:0] remainder;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> design/bba_if.sv
`default_nettype none
interface bba_cfg_if;
  import bba_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [ADDR_W-1:0]    data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

interface bba_req_if;
  import bba_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [ADDR_W-1:0] block_address;
  modport source(output valid, mode, block_address, input ready);
  modport sink(input valid, mode, block_address, output ready);
endinterface

interface bba_rsp_if;
  import bba_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   granted_address;
  logic [CNT_W-1:0]    used_blocks;
  logic [CNT_W-1:0]    peak_blocks;
  logic [ADDR_W-1:0]   failure_total;
  modport source(output valid, status, granted_address, used_blocks, peak_blocks,
                 failure_total, input ready);
  modport sink(input valid, status, granted_address, used_blocks, peak_blocks,
               failure_total, output ready);
endinterface
`default_nettype wire

>>> design/bba_divider.sv
`default_nettype none
module bba_divider (
  input  logic               clk,
  input  logic               rst,
  input  bba_pkg::div_req_t  req,
  output bba_pkg::div_rsp_t  rsp
);
  import bba_pkg::*;

  logic              busy;
  logic              done;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dsh;
  logic [DIV_QW-1:0] q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CW'(DIV_QW - 1);
        rem  <= req.dividend;
        dsh  <= DIV_DW'({req.divisor, {(DIV_QW-1){1'b0}}});
        q    <= '0;
      end else if (busy) begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          q   <= {q[DIV_QW-2:0], 1'b1};
        end else begin
          q   <= {q[DIV_QW-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = q;
  assign rsp.remainder = SIZE_W'(rem);

endmodule
`default_nettype wire

>>> design/bitmap_block_allocator.sv
`default_nettype none
// Channel  Dir  Word
// cfg      in   index, data (0 pool base, 1 bytes per block, 2 blocks in the pool)
// req      in   mode, block_address
// rsp      out  status, granted_address, used_blocks, peak_blocks, failure_total
//
// Allocate: map words are read, one per cycle, until a free bit shows up; at most 32 with
// 1024 blocks. Free: a range check, an 11-step divider pass and a map read-modify-write;
// a misaligned address stops after the divider, one out of range after the range check,
// a null one at once. req is ready again the cycle after the result is loaded.
// After reset the map is set to all free, word by word; req is held off meanwhile.
// A result waits in the output register; a new req word is taken, its result waits.
module bitmap_block_allocator #(
  parameter int MAX_BLOCKS = 1024,
  parameter int WORD_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  bba_cfg_if.sink     cfg,
  bba_req_if.sink     req,
  bba_rsp_if.source   rsp
);
  import bba_pkg::*;

  localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int CAP       = (MAX_BLOCKS < (1 << CNT_W) - 1) ? MAX_BLOCKS : (1 << CNT_W) - 1;
  localparam logic [CNT_W-1:0] LIMIT_CAP = CNT_W'(CAP);
  localparam logic [CNT_W:0]   WORD_STEP = (CNT_W + 1)'(WORD_BITS);
  localparam logic [WORD_BITS-1:0] ONE_BIT = WORD_BITS'(1);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_SCAN  = 8'b00000100,
    S_MUL   = 8'b00001000,
    S_FCMP  = 8'b00010000,
    S_FDIV  = 8'b00100000,
    S_FRD   = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t state;

  logic [ADDR_W-1:0] base_reg;
  logic [SIZE_W-1:0] size_reg;
  logic [CNT_W-1:0]  nblk_reg;
  logic [CNT_W-1:0]  limit;
  logic [SIZE_W-1:0] size_eff;

  logic [CNT_W-1:0]  used_count;
  logic [CNT_W-1:0]  peak_count;
  logic [ADDR_W-1:0] fail_count;
  logic [CNT_W-1:0]  used_inc;
  logic [ADDR_W-1:0] fail_next;

  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rd_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [AW-1:0]        clr_addr;

  logic [AW-1:0]        iss_addr;
  logic [CNT_W:0]       iss_base;
  logic                 iss_go;
  logic                 chk_valid;
  logic [AW-1:0]        chk_addr;
  logic [CNT_W-1:0]     chk_base;
  logic [CNT_W-1:0]     chk_rem;
  logic [WORD_BITS-1:0] chk_mask;
  logic [WORD_BITS-1:0] chk_hits;
  logic                 chk_last;
  logic [BW-1:0]        hit_pos;

  logic [CNT_W-1:0]  grant_idx;
  logic [DIV_DW-1:0] prod;
  status_t           res_status;
  logic              res_grant;

  logic [ADDR_W-1:0] offset;
  logic [DIV_DW-1:0] lim_prod;
  logic              in_range;
  logic [AW-1:0]     free_word;
  logic [BW-1:0]     free_pos;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                rsp_valid;
  logic                rsp_load;
  logic [STATUS_W-1:0] rsp_status;
  logic [ADDR_W-1:0]   rsp_granted;
  logic [CNT_W-1:0]    rsp_used;
  logic [CNT_W-1:0]    rsp_peak;
  logic [ADDR_W-1:0]   rsp_fail;

  assign limit     = (nblk_reg < LIMIT_CAP) ? nblk_reg : LIMIT_CAP;
  assign size_eff  = (size_reg == '0) ? SIZE_W'(1) : size_reg;
  assign used_inc  = used_count + 1'b1;
  assign fail_next = (fail_count == '1) ? fail_count : fail_count + 1'b1;

  assign iss_go   = iss_base < {1'b0, limit};
  assign chk_rem  = limit - chk_base;
  assign chk_last = ({1'b0, chk_base} + WORD_STEP) >= {1'b0, limit};
  assign chk_hits = rd_data & chk_mask;
  assign in_range = offset < ADDR_W'(lim_prod);
  assign rsp_load = (state == S_DONE) && (!rsp_valid || rsp.ready);

  always_comb begin
    if (chk_rem >= CNT_W'(WORD_BITS)) begin
      chk_mask = '1;
    end else begin
      chk_mask = ~({WORD_BITS{1'b1}} << chk_rem[BW-1:0]);
    end
  end

  always_comb begin
    hit_pos = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (chk_hits[j]) begin
        hit_pos = BW'(j);
      end
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = iss_addr;
    wr_en   = 1'b0;
    wr_addr = chk_addr;
    wr_data = rd_data;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '1;
      end
      S_SCAN: begin
        rd_en   = iss_go;
        wr_en   = chk_valid && (chk_hits != '0);
        wr_data = rd_data & ~(ONE_BIT << hit_pos);
      end
      S_FDIV: begin
        rd_en   = div_rsp.done && (div_rsp.remainder == '0);
        rd_addr = AW'(div_rsp.quotient >> BW);
      end
      S_FRD: begin
        wr_en   = !rd_data[free_pos];
        wr_addr = free_word;
        wr_data = rd_data | (ONE_BIT << free_pos);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= map_mem[rd_addr];
    end
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    div_req.start    = (state == S_FCMP) && in_range;
    div_req.dividend = offset[DIV_DW-1:0];
    div_req.divisor  = size_eff;
  end

  bba_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      chk_valid  <= 1'b0;
      base_reg   <= '0;
      size_reg   <= SIZE_W'(32);
      nblk_reg   <= CNT_W'(1024);
      used_count <= '0;
      peak_count <= '0;
      fail_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_BASE:  base_reg <= cfg.data;
          REG_SIZE:  size_reg <= cfg.data[SIZE_W-1:0];
          REG_COUNT: nblk_reg <= cfg.data[CNT_W-1:0];
          default: begin
          end
        endcase
      end

      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(MAP_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            res_grant <= 1'b0;
            if (req.mode == MODE_ALLOC) begin
              if (limit == '0) begin
                res_status <= ST_EXHAUSTED;
                fail_count <= fail_next;
                state      <= S_DONE;
              end else begin
                iss_addr  <= '0;
                iss_base  <= '0;
                chk_valid <= 1'b0;
                state     <= S_SCAN;
              end
            end else if (req.block_address == '0) begin
              res_status <= ST_NULL;
              state      <= S_DONE;
            end else begin
              offset   <= req.block_address - base_reg;
              lim_prod <= DIV_DW'(limit) * DIV_DW'(size_eff);
              state    <= S_FCMP;
            end
          end
        end
        S_SCAN: begin
          if (iss_go) begin
            iss_addr <= iss_addr + 1'b1;
            iss_base <= iss_base + WORD_STEP;
          end
          chk_addr <= iss_addr;
          chk_base <= iss_base[CNT_W-1:0];
          if (chk_valid && (chk_hits != '0)) begin
            grant_idx  <= chk_base + CNT_W'(hit_pos);
            used_count <= used_inc;
            if (used_inc > peak_count) begin
              peak_count <= used_inc;
            end
            res_status <= ST_OK;
            res_grant  <= 1'b1;
            chk_valid  <= 1'b0;
            state      <= S_MUL;
          end else if (chk_valid && chk_last) begin
            res_status <= ST_EXHAUSTED;
            fail_count <= fail_next;
            chk_valid  <= 1'b0;
            state      <= S_DONE;
          end else begin
            chk_valid <= iss_go;
          end
        end
        S_MUL: begin
          prod  <= DIV_DW'(grant_idx) * DIV_DW'(size_eff);
          state <= S_DONE;
        end
        S_FCMP: begin
          if (in_range) begin
            state <= S_FDIV;
          end else begin
            res_status <= ST_RANGE;
            state      <= S_DONE;
          end
        end
        S_FDIV: begin
          if (div_rsp.done) begin
            if (div_rsp.remainder != '0) begin
              res_status <= ST_MISALIGNED;
              state      <= S_DONE;
            end else begin
              free_word <= AW'(div_rsp.quotient >> BW);
              free_pos  <= div_rsp.quotient[BW-1:0];
              state     <= S_FRD;
            end
          end
        end
        S_FRD: begin
          if (rd_data[free_pos]) begin
            res_status <= ST_DOUBLE_FREE;
          end else begin
            res_status <= ST_OK;
            if (used_count != '0) begin
              used_count <= used_count - 1'b1;
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_load) begin
            rsp_status  <= res_status;
            rsp_granted <= res_grant ? base_reg + ADDR_W'(prod) : '0;
            rsp_used    <= used_count;
            rsp_peak    <= peak_count;
            rsp_fail    <= fail_count;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cfg.ready           = 1'b1;
  assign req.ready           = (state == S_IDLE);
  assign rsp.valid           = rsp_valid;
  assign rsp.status          = rsp_status;
  assign rsp.granted_address = rsp_granted;
  assign rsp.used_blocks     = rsp_used;
  assign rsp.peak_blocks     = rsp_peak;
  assign rsp.failure_total   = rsp_fail;

endmodule
`default_nettype wire

>>> design/bba_checker.sv
`default_nettype none
module bba_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  logic [2:0]  status,
  input  logic [31:0] granted,
  input  logic [10:0] used,
  input  logic [10:0] peak,
  input  logic [31:0] fail
);

  logic [1:0]  outstanding;
  logic [10:0] last_used;
  logic [10:0] last_peak;
  logic [31:0] last_fail;
  logic        in_acc;
  logic        out_acc;

  assign in_acc  = req_valid && req_ready;
  assign out_acc = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
      last_used   <= '0;
      last_peak   <= '0;
      last_fail   <= '0;
    end else begin
      outstanding <= outstanding + {1'b0, in_acc} - {1'b0, out_acc};
      if (out_acc) begin
        last_used <= used;
        last_peak <= peak;
        last_fail <= fail;
      end
    end
  end

  a_rsp_has_req: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> outstanding != 2'd0)
    else $error("response without an accepted request");

  a_peak_order: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (peak >= used) && (peak >= last_peak))
    else $error("peak count below used count or decreasing");

  a_fail_rises: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> fail >= last_fail)
    else $error("failure count decreased");

  a_used_step: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ({1'b0, used} == {1'b0, last_used}) ||
                  ({1'b0, used} == {1'b0, last_used} + 12'd1) ||
                  ({1'b0, used} + 12'd1 == {1'b0, last_used}))
    else $error("used count moved by more than one block");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(granted))
    else $error("stalled response word changed");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .granted   (rsp.granted_address),
  .used      (rsp.used_blocks),
  .peak      (rsp.peak_blocks),
  .fail      (rsp.failure_total)
);
`default_nettype wire
